// File: rtl/core/hgpg_pkg.sv
// Package for the hexagonal grid point generator: register indexes, widths,
// controller states and the command and status bundles between control and datapath.
// No dependencies.
package hgpg_pkg;

  localparam int SPACING_BITS = 31;
  localparam int SQ_BITS = 64;
  localparam int REG_IDX_BITS = 3;

  typedef logic [REG_IDX_BITS-1:0] reg_idx_t;

  localparam reg_idx_t REG_X_LOW   = 3'd0;
  localparam reg_idx_t REG_Y_LOW   = 3'd1;
  localparam reg_idx_t REG_X_HIGH  = 3'd2;
  localparam reg_idx_t REG_Y_HIGH  = 3'd3;
  localparam reg_idx_t REG_SPACING = 3'd4;

  localparam logic [SQ_BITS-1:0] SQ_BIT_INIT = 64'h4000_0000_0000_0000;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SQUARE,
    ST_TRIPLE,
    ST_ROOT,
    ST_RSTEP,
    ST_MOD_Y,
    ST_MOD_X0,
    ST_MOD_XS,
    ST_FINISH,
    ST_CAPTURE,
    ST_ADV_X,
    ST_ADV_ROW,
    ST_EMIT
  } state_t;

  typedef enum logic [1:0] {
    REM_Y,
    REM_X0,
    REM_XS
  } rem_sel_t;

  typedef struct packed {
    logic     capture;
    logic     square;
    logic     triple;
    logic     root_step;
    logic     set_step;
    logic     rem_start;
    rem_sel_t start_sel;
    logic     rem_store;
    rem_sel_t store_sel;
    logic     finish;
    logic     wrap;
    logic     adv_x;
    logic     adv_row;
    logic     load_out;
    logic     out_last;
    logic     out_bad;
  } dp_cmd_t;

  typedef struct packed {
    logic bad;
    logic x_fits;
    logic y_fits;
    logic start_fits;
    logic root_last;
    logic rem_done;
  } dp_stat_t;

endpackage

// File: rtl/core/hgpg_regs.sv
// Configuration register file of the hexagonal grid point generator, APB-style port.
// Depends on hgpg_pkg.
module hgpg_regs
  import hgpg_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_W = (COORD_BITS > 32) ? 6 : 5
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    psel,
  input  logic                    penable,
  input  logic                    pwrite,
  input  logic [ADDR_W-1:0]       paddr,
  input  logic [DATA_W-1:0]       pwdata,
  output logic [DATA_W-1:0]       prdata,
  output logic                    pready,
  output logic [COORD_BITS-1:0]   x_low,
  output logic [COORD_BITS-1:0]   y_low,
  output logic [COORD_BITS-1:0]   x_high,
  output logic [COORD_BITS-1:0]   y_high,
  output logic [SPACING_BITS-1:0] spacing
);

  localparam logic [SPACING_BITS-1:0] SP_RESET = SPACING_BITS'(64'd1 << FRAC_BITS);

  logic [COORD_BITS-1:0]   xl_r, yl_r, xh_r, yh_r;
  logic [SPACING_BITS-1:0] sp_r;
  reg_idx_t                idx;
  logic                    wr;

  assign idx   = paddr[ADDR_W-1 -: REG_IDX_BITS];
  assign wr    = psel & penable & pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      xl_r <= '0;
      yl_r <= '0;
      xh_r <= '0;
      yh_r <= '0;
      sp_r <= SP_RESET;
    end else if (wr) begin
      case (idx)
        REG_X_LOW:   xl_r <= pwdata[COORD_BITS-1:0];
        REG_Y_LOW:   yl_r <= pwdata[COORD_BITS-1:0];
        REG_X_HIGH:  xh_r <= pwdata[COORD_BITS-1:0];
        REG_Y_HIGH:  yh_r <= pwdata[COORD_BITS-1:0];
        REG_SPACING: sp_r <= pwdata[SPACING_BITS-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_X_LOW:   prdata = DATA_W'(xl_r);
      REG_Y_LOW:   prdata = DATA_W'(yl_r);
      REG_X_HIGH:  prdata = DATA_W'(xh_r);
      REG_Y_HIGH:  prdata = DATA_W'(yh_r);
      REG_SPACING: prdata = DATA_W'(sp_r);
      default:     prdata = '0;
    endcase
  end

  assign x_low   = xl_r;
  assign y_low   = yl_r;
  assign x_high  = xh_r;
  assign y_high  = yh_r;
  assign spacing = sp_r;

endmodule

// File: rtl/core/hgpg_rem.sv
// Bit-serial restoring remainder unit, one dividend bit per cycle.
// Depends on nothing beyond its parameters.
module hgpg_rem #(
  parameter int DVD_BITS = 32,
  parameter int DVS_BITS = 31
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  logic [DVD_BITS-1:0] dividend,
  input  logic [DVS_BITS-1:0] divisor,
  output logic                done,
  output logic [DVS_BITS-1:0] rem
);

  localparam int CNT_W = $clog2(DVD_BITS + 1);

  logic                run_r, done_r;
  logic [CNT_W-1:0]    cnt_r;
  logic [DVD_BITS-1:0] dvd_r;
  logic [DVS_BITS-1:0] dvs_r, rem_r;
  logic [DVS_BITS:0]   trial, diff;
  logic                ge;

  assign trial = {rem_r, dvd_r[DVD_BITS-1]};
  assign ge    = trial >= {1'b0, dvs_r};
  assign diff  = trial - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= !start && run_r && (cnt_r == CNT_W'(1));
      if (start) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == CNT_W'(1)) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
      rem_r <= '0;
      cnt_r <= CNT_W'(DVD_BITS);
    end else if (run_r) begin
      rem_r <= ge ? diff[DVS_BITS-1:0] : trial[DVS_BITS-1:0];
      dvd_r <= {dvd_r[DVD_BITS-2:0], 1'b0};
      cnt_r <= cnt_r - CNT_W'(1);
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

// File: rtl/core/hgpg_dp.sv
// Datapath of the hexagonal grid point generator: cursor, row step root, offsets and result.
// Depends on hgpg_pkg and hgpg_rem.
module hgpg_dp
  import hgpg_pkg::*;
#(
  parameter int COORD_BITS = 32
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic signed [COORD_BITS-1:0]  x_low,
  input  logic signed [COORD_BITS-1:0]  y_low,
  input  logic signed [COORD_BITS-1:0]  x_high,
  input  logic signed [COORD_BITS-1:0]  y_high,
  input  logic [SPACING_BITS-1:0]       spacing,
  input  dp_cmd_t                       cmd,
  output dp_stat_t                      stat,
  output logic signed [COORD_BITS-1:0]  out_point_x,
  output logic signed [COORD_BITS-1:0]  out_point_y,
  output logic                          out_last_point,
  output logic                          out_bad_setup
);

  localparam int W = ((COORD_BITS > SPACING_BITS) ? COORD_BITS : SPACING_BITS) + 2;
  localparam int OFF_BITS = SPACING_BITS - 1;

  logic signed [W-1:0] x0w, y0w, x1w, y1w, spw, hw, rsw, cxw, cyw;
  logic signed [W-1:0] nx, ny, start_x, xs, dy, dx0, dxs, offxw, offyw, sum_x, sum_y;

  logic signed [COORD_BITS-1:0] curx_r, cury_r, resx_r, resy_r, outx_r, outy_r;
  logic                         shifted_r, outlast_r, outbad_r;
  logic [SPACING_BITS-1:0]      rs_r, ry_r, rx0_r, rxs_r, rs_calc;
  logic [OFF_BITS-1:0]          offx_r, offy_r;
  logic [SQ_BITS-1:0]           v_r, root_r, sqb_r, trial, root_inc;
  logic [2*SPACING_BITS-1:0]    sq;

  logic [COORD_BITS-1:0]   rem_dvd;
  logic [SPACING_BITS-1:0] rem_dvs, rem_val;
  logic                    rem_done, xs_ok, rows_ok, use_r2;

  assign x0w = {{(W-COORD_BITS){x_low[COORD_BITS-1]}}, x_low};
  assign y0w = {{(W-COORD_BITS){y_low[COORD_BITS-1]}}, y_low};
  assign x1w = {{(W-COORD_BITS){x_high[COORD_BITS-1]}}, x_high};
  assign y1w = {{(W-COORD_BITS){y_high[COORD_BITS-1]}}, y_high};
  assign cxw = {{(W-COORD_BITS){curx_r[COORD_BITS-1]}}, curx_r};
  assign cyw = {{(W-COORD_BITS){cury_r[COORD_BITS-1]}}, cury_r};
  assign spw = {{(W-SPACING_BITS){1'b0}}, spacing};
  assign hw  = {{(W-OFF_BITS){1'b0}}, spacing[SPACING_BITS-1:1]};
  assign rsw = {{(W-SPACING_BITS){1'b0}}, rs_r};

  assign nx      = cxw + spw;
  assign ny      = cyw + rsw;
  assign start_x = shifted_r ? x0w : x0w + hw;
  assign xs      = x0w + hw;
  assign dy      = y1w - y0w;
  assign dx0     = x1w - x0w;
  assign dxs     = x1w - xs;

  assign stat.bad        = (x0w > x1w) || (y0w > y1w) || (spacing == '0);
  assign stat.x_fits     = nx <= x1w;
  assign stat.y_fits     = ny <= y1w;
  assign stat.start_fits = start_x <= x1w;
  assign stat.root_last  = sqb_r[0];
  assign stat.rem_done   = rem_done;

  assign sq       = spacing * spacing;
  assign trial    = root_r + sqb_r;
  assign root_inc = root_r + SQ_BITS'(1);
  assign rs_calc  = root_inc[SPACING_BITS:1];

  always_comb begin
    case (cmd.start_sel)
      REM_Y: begin
        rem_dvd = dy[COORD_BITS-1:0];
        rem_dvs = rs_calc;
      end
      REM_X0: begin
        rem_dvd = dx0[COORD_BITS-1:0];
        rem_dvs = spacing;
      end
      REM_XS: begin
        rem_dvd = dxs[COORD_BITS-1:0];
        rem_dvs = spacing;
      end
      default: begin
        rem_dvd = dx0[COORD_BITS-1:0];
        rem_dvs = spacing;
      end
    endcase
  end

  hgpg_rem #(
    .DVD_BITS(COORD_BITS),
    .DVS_BITS(SPACING_BITS)
  ) u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.rem_start),
    .dividend (rem_dvd),
    .divisor  (rem_dvs),
    .done     (rem_done),
    .rem      (rem_val)
  );

  assign xs_ok   = xs <= x1w;
  assign rows_ok = dy >= rsw;
  assign use_r2  = xs_ok && rows_ok && (rxs_r < rx0_r);

  assign offxw = {{(W-OFF_BITS){1'b0}}, offx_r};
  assign offyw = {{(W-OFF_BITS){1'b0}}, offy_r};
  assign sum_x = cxw + offxw;
  assign sum_y = cyw + offyw;

  always_ff @(posedge clk) begin
    if (cmd.square) begin
      v_r <= {{(SQ_BITS-2*SPACING_BITS){1'b0}}, sq};
    end else if (cmd.triple) begin
      v_r    <= v_r + {v_r[SQ_BITS-2:0], 1'b0};
      root_r <= '0;
      sqb_r  <= SQ_BIT_INIT;
    end else if (cmd.root_step) begin
      if (v_r >= trial) begin
        v_r    <= v_r - trial;
        root_r <= (root_r >> 1) + sqb_r;
      end else begin
        root_r <= root_r >> 1;
      end
      sqb_r <= sqb_r >> 2;
    end
    if (cmd.set_step) begin
      rs_r <= rs_calc;
    end
    if (cmd.rem_store) begin
      case (cmd.store_sel)
        REM_Y:   ry_r  <= rem_val;
        REM_X0:  rx0_r <= rem_val;
        REM_XS:  rxs_r <= rem_val;
        default: ;
      endcase
    end
    if (cmd.finish) begin
      offx_r <= use_r2 ? rxs_r[SPACING_BITS-1:1] : rx0_r[SPACING_BITS-1:1];
      offy_r <= ry_r[SPACING_BITS-1:1];
    end
    if (cmd.capture) begin
      resx_r <= sum_x[COORD_BITS-1:0];
      resy_r <= sum_y[COORD_BITS-1:0];
    end
    if (cmd.wrap) begin
      curx_r    <= x_low;
      cury_r    <= y_low;
      shifted_r <= 1'b0;
    end else if (cmd.adv_x) begin
      if (stat.x_fits) begin
        curx_r <= nx[COORD_BITS-1:0];
      end
    end else if (cmd.adv_row) begin
      if (stat.y_fits) begin
        cury_r    <= ny[COORD_BITS-1:0];
        shifted_r <= ~shifted_r;
        if (stat.start_fits) begin
          curx_r <= start_x[COORD_BITS-1:0];
        end
      end
    end
    if (cmd.load_out) begin
      outx_r    <= cmd.out_bad ? '0 : resx_r;
      outy_r    <= cmd.out_bad ? '0 : resy_r;
      outlast_r <= cmd.out_last;
      outbad_r  <= cmd.out_bad;
    end
  end

  assign out_point_x    = outx_r;
  assign out_point_y    = outy_r;
  assign out_last_point = outlast_r;
  assign out_bad_setup  = outbad_r;

endmodule

// File: rtl/core/hgpg_ctrl.sv
// Controller of the hexagonal grid point generator: sequences restart, walk and handshakes.
// Depends on hgpg_pkg.
module hgpg_ctrl
  import hgpg_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  logic     in_restart,
  output logic     out_valid,
  input  logic     out_ready,
  output dp_cmd_t  cmd,
  input  dp_stat_t stat
);

  state_t state_r, state_nxt;
  logic   extents_r, extents_nxt;
  logic   last_r, last_nxt;
  logic   bad_r, bad_nxt;
  logic   pass_r, pass_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      extents_r   <= 1'b0;
      last_r      <= 1'b0;
      bad_r       <= 1'b0;
      pass_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      extents_r   <= extents_nxt;
      last_r      <= last_nxt;
      bad_r       <= bad_nxt;
      pass_r      <= pass_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    extents_nxt   = extents_r;
    last_nxt      = last_r;
    bad_nxt       = bad_r;
    pass_nxt      = pass_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    cmd           = '0;
    in_ready      = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          last_nxt = 1'b0;
          if (stat.bad) begin
            if (in_restart) begin
              extents_nxt = 1'b0;
            end
            bad_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else if (in_restart) begin
            state_nxt = ST_SQUARE;
          end else if (!extents_r) begin
            bad_nxt   = 1'b1;
            state_nxt = ST_EMIT;
          end else begin
            cmd.capture = 1'b1;
            bad_nxt     = 1'b0;
            state_nxt   = ST_ADV_X;
          end
        end
      end
      ST_SQUARE: begin
        cmd.square = 1'b1;
        state_nxt  = ST_TRIPLE;
      end
      ST_TRIPLE: begin
        cmd.triple = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        cmd.root_step = 1'b1;
        if (stat.root_last) begin
          state_nxt = ST_RSTEP;
        end
      end
      ST_RSTEP: begin
        cmd.set_step  = 1'b1;
        cmd.rem_start = 1'b1;
        cmd.start_sel = REM_Y;
        state_nxt     = ST_MOD_Y;
      end
      ST_MOD_Y: begin
        if (stat.rem_done) begin
          cmd.rem_store = 1'b1;
          cmd.store_sel = REM_Y;
          cmd.rem_start = 1'b1;
          cmd.start_sel = REM_X0;
          state_nxt     = ST_MOD_X0;
        end
      end
      ST_MOD_X0: begin
        if (stat.rem_done) begin
          cmd.rem_store = 1'b1;
          cmd.store_sel = REM_X0;
          cmd.rem_start = 1'b1;
          cmd.start_sel = REM_XS;
          state_nxt     = ST_MOD_XS;
        end
      end
      ST_MOD_XS: begin
        if (stat.rem_done) begin
          cmd.rem_store = 1'b1;
          cmd.store_sel = REM_XS;
          state_nxt     = ST_FINISH;
        end
      end
      ST_FINISH: begin
        cmd.finish  = 1'b1;
        cmd.wrap    = 1'b1;
        extents_nxt = 1'b1;
        state_nxt   = ST_CAPTURE;
      end
      ST_CAPTURE: begin
        cmd.capture = 1'b1;
        bad_nxt     = 1'b0;
        state_nxt   = ST_ADV_X;
      end
      ST_ADV_X: begin
        cmd.adv_x = 1'b1;
        if (stat.x_fits) begin
          last_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else begin
          pass_nxt  = 1'b0;
          state_nxt = ST_ADV_ROW;
        end
      end
      ST_ADV_ROW: begin
        cmd.adv_row = 1'b1;
        if (!stat.y_fits) begin
          cmd.wrap  = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else if (stat.start_fits) begin
          last_nxt  = 1'b0;
          state_nxt = ST_EMIT;
        end else if (pass_r) begin
          cmd.wrap  = 1'b1;
          last_nxt  = 1'b1;
          state_nxt = ST_EMIT;
        end else begin
          pass_nxt = 1'b1;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out  = 1'b1;
          cmd.out_last  = last_r;
          cmd.out_bad   = bad_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

// File: rtl/core/hexagonal_grid_point_generator.sv
// Top level of the hexagonal grid point generator: register file, controller and datapath.
// Depends on hgpg_pkg, hgpg_regs, hgpg_ctrl and hgpg_dp.
//
//   Channel   Handshake          Payload
//   input     in_valid/in_ready  in_restart
//   result    out_valid/out_ready out_point_x, out_point_y, out_last_point, out_bad_setup
//   config    psel/penable/pready paddr, pwdata, pwrite, prdata
//
// A next-point result is set by the add and compare of the column step and up to two row
// steps, then loaded into the output register; the input is taken again only once the
// controller is back in idle, so one transaction is in flight at a time.
// A restart result follows a 32-step square root for the row step, then three bit-serial
// remainders in one shared remainder unit, then the first point.
// Reset is synchronous and needs no clearing pass; a restart is required before points.
// While a result waits on out_ready, one more transaction may be accepted; its result then
// waits in ST_EMIT and the input is refused until it can be loaded.
module hexagonal_grid_point_generator
  import hgpg_pkg::*;
#(
  parameter int COORD_BITS = 32,
  parameter int FRAC_BITS  = 16,
  localparam int DATA_W = (COORD_BITS > 32) ? 64 : 32,
  localparam int ADDR_W = (COORD_BITS > 32) ? 6 : 5
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ADDR_W-1:0]            paddr,
  input  logic [DATA_W-1:0]            pwdata,
  output logic [DATA_W-1:0]            prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         in_restart,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [COORD_BITS-1:0] out_point_x,
  output logic signed [COORD_BITS-1:0] out_point_y,
  output logic                         out_last_point,
  output logic                         out_bad_setup
);

  logic [COORD_BITS-1:0]   x_low, y_low, x_high, y_high;
  logic [SPACING_BITS-1:0] spacing;
  dp_cmd_t                 cmd;
  dp_stat_t                stat;

  hgpg_regs #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .x_low   (x_low),
    .y_low   (y_low),
    .x_high  (x_high),
    .y_high  (y_high),
    .spacing (spacing)
  );

  hgpg_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_restart (in_restart),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .stat       (stat)
  );

  hgpg_dp #(
    .COORD_BITS(COORD_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .x_low          (x_low),
    .y_low          (y_low),
    .x_high         (x_high),
    .y_high         (y_high),
    .spacing        (spacing),
    .cmd            (cmd),
    .stat           (stat),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .out_bad_setup  (out_bad_setup)
  );

`ifndef ASSERT_OFF
  a_bad_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_setup |-> out_point_x == '0 && out_point_y == '0 && !out_last_point)
    else $error("bad setup result carries a point");

  a_one_at_a_time : assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while a transaction is in flight");

  a_result_from_work : assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a transaction in progress");
`endif

endmodule

// File: tb/tb_hexagonal_grid_point_generator.sv
// Self-checking testbench for the hexagonal grid point generator: a directed run through the
// corner cases, then random grid settings under varying idle patterns on both channels.
// Depends on hgpg_pkg and hexagonal_grid_point_generator.
module tb_hexagonal_grid_point_generator
  import hgpg_pkg::*;
();

  typedef bit [63:0] wide_t;
  localparam wide_t TOP_BIT = 64'h8000_0000_0000_0000;

  typedef struct packed {
    bit [31:0] x;
    bit [31:0] y;
    bit        last;
    bit        bad;
  } grid_point_t;

  class grid_point_tracker;
    bit [31:0]   x_lo, y_lo, x_hi, y_hi;
    bit [30:0]   pitch = 31'd65536;
    wide_t       cur_x, cur_y, off_x, off_y, row_pitch;
    bit          odd_row, walked;
    grid_point_t due_points[$];
    int unsigned errors;

    function void write_reg(reg_idx_t idx, bit [31:0] v);
      case (idx)
        REG_X_LOW:   x_lo = v;
        REG_Y_LOW:   y_lo = v;
        REG_X_HIGH:  x_hi = v;
        REG_Y_HIGH:  y_hi = v;
        REG_SPACING: pitch = v[30:0];
        default: ;
      endcase
    endfunction

    // Signed coordinates are moved into an unsigned space whose order matches signed order.
    function wide_t bias(bit [31:0] v);
      return {{32{v[31]}}, v} ^ TOP_BIT;
    endfunction

    function wide_t isqrt(wide_t v);
      wide_t res, b;
      res = '0;
      b = 64'h4000_0000_0000_0000;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= res + b) begin
          v -= res + b;
          res = (res >> 1) + b;
        end else begin
          res >>= 1;
        end
        b >>= 2;
      end
      return res;
    endfunction

    function bit setup_bad();
      return bias(x_lo) > bias(x_hi) || bias(y_lo) > bias(y_hi) || pitch == 0;
    endfunction

    function void walk_restart();
      wide_t x0, y0, x1, y1, sp, rows, xmax, ymax, xs, xm2;
      x0 = bias(x_lo);
      y0 = bias(y_lo);
      x1 = bias(x_hi);
      y1 = bias(y_hi);
      sp = wide_t'(pitch);
      row_pitch = (isqrt(3 * sp * sp) + 1) >> 1;
      rows = (y1 - y0) / row_pitch;
      ymax = y0 + rows * row_pitch;
      xmax = x0 + ((x1 - x0) / sp) * sp;
      if (rows >= 1) begin
        xs = x0 + (sp >> 1);
        if (xs >= x0 && xs <= x1) begin
          xm2 = xs + ((x1 - xs) / sp) * sp;
          if (xm2 > xmax) xmax = xm2;
        end
      end
      off_x = (x1 - xmax) >> 1;
      off_y = (y1 - ymax) >> 1;
      cur_x = x0;
      cur_y = y0;
      odd_row = 1'b0;
      walked = 1'b1;
    endfunction

    // Moves to the next point in row-major order and returns 1 when it wraps to the first.
    function bit step_cursor();
      wide_t x0, y0, x1, y1, sp, nx, ny, start;
      x0 = bias(x_lo);
      y0 = bias(y_lo);
      x1 = bias(x_hi);
      y1 = bias(y_hi);
      sp = wide_t'(pitch);
      nx = cur_x + sp;
      if (nx >= cur_x && nx <= x1) begin
        cur_x = nx;
        return 1'b0;
      end
      for (int pass = 0; pass < 2; pass++) begin
        ny = cur_y + row_pitch;
        if (ny < cur_y || ny > y1) break;
        cur_y = ny;
        odd_row = !odd_row;
        start = x0 + (odd_row ? (sp >> 1) : 64'd0);
        if (start >= x0 && start <= x1) begin
          cur_x = start;
          return 1'b0;
        end
      end
      cur_x = x0;
      cur_y = y0;
      odd_row = 1'b0;
      return 1'b1;
    endfunction

    function void note_request(bit restart);
      grid_point_t p;
      wide_t sum;
      bit bad;
      bad = setup_bad();
      if (restart) begin
        if (bad) walked = 1'b0;
        else walk_restart();
      end
      p = '0;
      if (bad || !walked) begin
        p.bad = 1'b1;
      end else begin
        sum = cur_x + off_x;
        p.x = sum[31:0];
        sum = cur_y + off_y;
        p.y = sum[31:0];
        p.last = step_cursor();
      end
      due_points = {due_points, p};
    endfunction

    function void flag(string what, logic [31:0] want, logic [31:0] got);
      errors++;
      $display("%0t: %s expected %h, got %h", $time, what, want, got);
    endfunction

    function void check_point(logic [31:0] px, logic [31:0] py, logic lp, logic bs);
      grid_point_t e;
      if (due_points.size() == 0) begin
        errors++;
        $display("%0t: result expected none, got x=%h y=%h last=%b bad=%b",
                 $time, px, py, lp, bs);
        return;
      end
      e = due_points.pop_front();
      if (px !== e.x) flag("point_x", e.x, px);
      if (py !== e.y) flag("point_y", e.y, py);
      if (lp !== e.last) flag("last_point", 32'(e.last), 32'(lp));
      if (bs !== e.bad) flag("bad_setup", 32'(e.bad), 32'(bs));
    endfunction

    function int pending();
      return due_points.size();
    endfunction
  endclass

  logic                clk = 1'b0;
  logic                rst_n;
  logic                psel, penable, pwrite;
  logic [4:0]          paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;
  logic                in_valid, in_restart;
  logic                in_ready;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic signed [31:0]  out_point_x, out_point_y;
  logic                out_last_point, out_bad_setup;

  int unsigned         send_idle, recv_idle;
  grid_point_tracker   grid;

  hexagonal_grid_point_generator i_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_restart     (in_restart),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_point_x    (out_point_x),
    .out_point_y    (out_point_y),
    .out_last_point (out_last_point),
    .out_bad_setup  (out_bad_setup)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      grid.check_point(out_point_x, out_point_y, out_last_point, out_bad_setup);
    out_ready <= ($urandom_range(0, 99) >= recv_idle);
  end

  task automatic send_request(bit restart);
    while ($urandom_range(0, 99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!in_ready);
    grid.note_request(restart);
  endtask

  // Lets every outstanding result drain so that the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (grid.pending() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic set_register(reg_idx_t idx, logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    grid.write_reg(idx, value);
  endtask

  task automatic configure(bit [4:0] which, logic [31:0] xl, logic [31:0] yl,
                           logic [31:0] xh, logic [31:0] yh, logic [31:0] sp);
    if (which[REG_X_LOW])   set_register(REG_X_LOW, xl);
    if (which[REG_Y_LOW])   set_register(REG_Y_LOW, yl);
    if (which[REG_X_HIGH])  set_register(REG_X_HIGH, xh);
    if (which[REG_Y_HIGH])  set_register(REG_Y_HIGH, yh);
    if (which[REG_SPACING]) set_register(REG_SPACING, sp);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  initial begin
    #10_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int          rand_items;
    int          xl, yl, xh, yh, n, kind;
    int unsigned sp;
    bit [4:0]    which;
    bit          first;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_restart = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    send_idle = 27;
    recv_idle = 78;
    rand_items = 0;
    grid = new();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Before any restart no point can be given; the reset settings form a one-point grid.
    send_request(1'b0);
    send_request(1'b1);
    send_request(1'b0);
    settle();
    configure(5'b00001, 32'h1, 0, 0, 0, 0);
    send_request(1'b1);
    settle();
    // A failed restart leaves the generator without extents even once settings are good.
    configure(5'b00001, 32'h0, 0, 0, 0, 0);
    send_request(1'b0);
    send_request(1'b1);
    settle();
    configure(5'b00010, 0, 32'h0001_0000, 0, 0, 0);
    send_request(1'b0);
    settle();
    configure(5'b10010, 0, 32'h0, 0, 0, 32'h0);
    send_request(1'b1);
    settle();
    // A single column, so every shifted row is empty and skipped.
    configure(5'b11111, 32'h0, 32'h0, 32'h0, 32'h0003_0000, 32'h0001_0000);
    send_request(1'b1);
    repeat (4) send_request(1'b0) ;
    settle();
    configure(5'b11111, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h7FFF_FFFF);
    send_request(1'b1);
    repeat (9) send_request(1'b0);
    settle();
    configure(5'b00100, 0, 0, 32'h0, 0, 0);
    repeat (2) send_request(1'b0);

    while (rand_items < 900) begin
      if (rand_items < 300) begin
        send_idle = 27;
        recv_idle = 78;
      end else if (rand_items < 600) begin
        send_idle = 78;
        recv_idle = 27;
      end else begin
        send_idle = 0;
        recv_idle = 0;
      end
      settle();
      kind = $urandom_range(0, 9);
      sp = $urandom_range(32'h4000, 32'h40000);
      xl = int'($urandom) >>> 1;
      yl = int'($urandom) >>> 1;
      xh = xl + int'($urandom_range(0, 5) * sp + $urandom_range(0, sp));
      yh = yl + int'($urandom_range(0, 3) * sp + $urandom_range(0, sp));
      if (kind == 7) begin
        case ($urandom_range(0, 2))
          0: xh = xl - 1 - int'($urandom_range(0, sp));
          1: yh = yl - 1 - int'($urandom_range(0, sp));
          default: sp = 0;
        endcase
      end else if (kind == 8) begin
        xl = $urandom;
        yl = $urandom;
        xh = $urandom;
        yh = $urandom;
        sp = $urandom;
      end else if (kind == 9) begin
        if ($urandom_range(0, 1)) xl = int'(32'h8000_0000);
        if ($urandom_range(0, 1)) yl = int'(32'h8000_0000);
        xh = int'(32'h7FFF_FFFF);
        yh = int'(32'h7FFF_FFFF);
        sp = $urandom_range(32'h0800_0000, 32'h7FFF_FFFF);
      end
      which = ($urandom_range(0, 9) == 0) ? 5'($urandom) : 5'h1F;
      configure(which, xl, yl, xh, yh, sp);
      first = ($urandom_range(0, 9) != 0);
      n = $urandom_range(8, 40);
      for (int k = 0; k < n; k++) begin
        send_request((k == 0) ? first : ($urandom_range(0, 19) == 0));
        rand_items++;
      end
    end

    settle();
    if (grid.errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
